// ===== hw/rtl/fse_pkg.sv =====
// Shared types and constants for the Fibonacci search engine.
// Used by fse_front, fse_back and fibonacci_search_engine_unit; no dependencies.
package fse_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;
  localparam int POS_W = 10;
  localparam int FIB_W = 12;
  localparam int BASE_W = 13;
  localparam int Q_DEPTH = 2;
  localparam logic [CNT_W-1:0] ENTRY_COUNT_RESET = 11'd1024;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_SEARCH = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic                    in_range;
    logic [IDX_W-1:0]        idx;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

// ===== hw/rtl/fse_front.sv =====
// Front end of the Fibonacci search engine: accepts requests, classifies them
// and holds them in a short command queue. Depends on fse_pkg.
module fse_front #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            kind,
  input  logic [fse_pkg::IDX_W-1:0]       entry_index,
  input  logic signed [fse_pkg::VAL_W-1:0] value,
  output logic                            cmd_valid,
  output fse_pkg::cmd_t                   cmd,
  input  logic                            cmd_take
);
  import fse_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);

  cmd_t              q [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;
  logic              do_push;
  logic              do_pop;
  cmd_t              incoming;

  assign full = (count == (PTR_W+1)'(Q_DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = cmd_take && cmd_valid;

  always_comb begin
    incoming.kind = kind_t'(kind);
    incoming.in_range = (int'(entry_index) < TABLE_DEPTH);
    incoming.idx = entry_index;
    incoming.value = value;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10: count <= count + 1'b1;
        2'b01: count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/fse_back.sv =====
// Back end of the Fibonacci search engine: table memory, the search sequencer
// and the result register. Depends on fse_pkg.
module fse_back #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  fse_pkg::cmd_t             cmd,
  output logic                      cmd_take,
  input  logic [fse_pkg::CNT_W-1:0] entry_count,
  output logic                      empty,
  input  logic                      pop,
  output logic                      found,
  output logic [fse_pkg::POS_W-1:0] position
);
  import fse_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int RW = (AW > BASE_W) ? AW : BASE_W;
  localparam int LW = (AW > IDX_W) ? AW : IDX_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_BUILD  = 7'b0000010,
    S_PROBE  = 7'b0000100,
    S_CMP    = 7'b0001000,
    S_CHECK  = 7'b0010000,
    S_CHKCMP = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  logic signed [VAL_W-1:0]  mem [TABLE_DEPTH];
  logic signed [VAL_W-1:0]  rd_data;
  logic [AW-1:0]            rd_addr;
  logic [RW-1:0]            rd_ext;
  logic [LW-1:0]            wr_ext;
  logic                     mem_we;

  state_t                   state;
  state_t                   state_next;
  logic signed [VAL_W-1:0]  key;
  logic [FIB_W-1:0]         n;
  logic [FIB_W-1:0]         f;
  logic [FIB_W-1:0]         f1;
  logic [FIB_W-1:0]         f2;
  logic signed [BASE_W-1:0] base;
  logic signed [BASE_W-1:0] probe;
  logic signed [BASE_W-1:0] probe_raw;
  logic signed [BASE_W-1:0] n_s;
  logic signed [BASE_W-1:0] next_pos;
  logic                     res_found;
  logic [POS_W-1:0]         res_pos;
  logic                     out_valid;
  logic                     out_load;
  logic [FIB_W-1:0]         n_sat;

  assign n_sat = (int'(entry_count) > TABLE_DEPTH) ? FIB_W'(TABLE_DEPTH)
                                                   : FIB_W'(entry_count);
  assign n_s = $signed({1'b0, n});
  assign next_pos = base + BASE_W'(1);

  always_comb begin
    probe_raw = base + $signed({1'b0, f2});
    if (probe_raw > n_s - BASE_W'(1)) begin
      probe_raw = n_s - BASE_W'(1);
    end
    if (probe_raw < 0) begin
      probe_raw = '0;
    end
  end

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign mem_we = cmd_take && (cmd.kind == KIND_LOAD) && cmd.in_range;
  assign wr_ext = LW'(cmd.idx);
  assign rd_ext = (state == S_CHECK) ? RW'($unsigned(next_pos)) : RW'($unsigned(probe_raw));
  assign rd_addr = rd_ext[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ext[AW-1:0]] <= cmd.value;
    end
    rd_data <= mem[rd_addr];
  end

  assign out_load = (state == S_DONE) && (!out_valid || pop);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_take && (cmd.kind == KIND_SEARCH)) begin
          state_next = S_BUILD;
        end
      end
      S_BUILD: begin
        if (f >= n) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        state_next = (f > FIB_W'(1)) ? S_CMP : S_CHECK;
      end
      S_CMP: begin
        state_next = (rd_data == key) ? S_DONE : S_PROBE;
      end
      S_CHECK: begin
        if ((f1 != '0) && (next_pos >= 0) && (next_pos < n_s)) begin
          state_next = S_CHKCMP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CHKCMP: state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        key <= cmd.value;
        n <= n_sat;
        f <= FIB_W'(1);
        f1 <= FIB_W'(1);
        f2 <= '0;
        base <= -BASE_W'(1);
        res_found <= 1'b0;
        res_pos <= '0;
      end
      S_BUILD: begin
        if (f < n) begin
          f2 <= f1;
          f1 <= f;
          f <= f + f1;
        end
      end
      S_PROBE: begin
        probe <= probe_raw;
      end
      S_CMP: begin
        if (rd_data < key) begin
          f <= f1;
          f1 <= f2;
          f2 <= f1 - f2;
          base <= probe;
        end else if (rd_data > key) begin
          f <= f2;
          f1 <= f1 - f2;
          f2 <= (f2 << 1) - f1;
        end else begin
          res_found <= 1'b1;
          res_pos <= POS_W'($unsigned(probe));
        end
      end
      S_CHKCMP: begin
        if (rd_data == key) begin
          res_found <= 1'b1;
          res_pos <= POS_W'($unsigned(next_pos));
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      found <= res_found;
      position <= res_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;

endmodule

// ===== hw/rtl/fibonacci_search_engine_unit.sv =====
// Fibonacci search engine: a load is held in the command queue and written to the table
// when the back end is idle and takes it from the queue.
// A search first builds the Fibonacci numbers step by step, then probes the table memory's
// read port: each probe reads an entry and compares it with the key, and a last check may
// read the entry after the base; one search runs at a time.
// Reset clears the command queue and the sequencer and sets entry_count to 1024; table contents
// are undefined until loaded, and no clearing pass runs. Depends on fse_pkg, fse_front, fse_back.
module fibonacci_search_engine_unit #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic                             kind,
  input  logic [fse_pkg::IDX_W-1:0]        entry_index,
  input  logic signed [fse_pkg::VAL_W-1:0] value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fse_pkg::CNT_W-1:0]        cfg_data,
  output logic                             empty,
  input  logic                             pop,
  output logic                             found,
  output logic [fse_pkg::POS_W-1:0]        position
);
  import fse_pkg::*;

  logic [CNT_W-1:0] entry_count;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= ENTRY_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  fse_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .kind        (kind),
    .entry_index (entry_index),
    .value       (value),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take)
  );

  fse_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_take    (cmd_take),
    .entry_count (entry_count),
    .empty       (empty),
    .pop         (pop),
    .found       (found),
    .position    (position)
  );

endmodule
